### hdl/ept_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ept_pkg;

  // Phase codes
  localparam logic [1:0] PH_OBSERVE = 2'd0;
  localparam logic [1:0] PH_CONTROL = 2'd1;
  localparam logic [1:0] PH_STANDBY = 2'd2;

  // Item opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_SET_DUR = 1'b1;

  // Result status codes
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_ILLEGAL = 1'b1;

  // Register indexes
  localparam int unsigned REG_ENABLE  = 0;
  localparam int unsigned REG_MAX_STEP = 1;
  localparam int unsigned REG_MIN_DUR = 2;
  localparam int unsigned REG_MAX_DUR = 3;
  localparam int unsigned NUM_REGS    = 4;
  localparam int unsigned ADDR_W      = $clog2(NUM_REGS) + 2;

  // Widths
  localparam int unsigned TIMER_W = 17;
  localparam int unsigned DUR_W   = 14;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned STEP_W  = 32;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Reset values
  localparam logic [MS_W-1:0]  MAX_STEP_RST = 16'd1000;
  localparam logic [MS_W-1:0]  MIN_DUR_RST  = 16'd10;
  localparam logic [MS_W-1:0]  MAX_DUR_RST  = 16'd10000;
  localparam logic [DUR_W-1:0] OBS_DUR_RST  = 14'd100;
  localparam logic [DUR_W-1:0] CTL_DUR_RST  = 14'd800;
  localparam logic [DUR_W-1:0] STB_DUR_RST  = 14'd100;

  typedef struct packed {
    logic            enable;
    logic [MS_W-1:0] max_step_ms;
    logic [MS_W-1:0] min_duration_ms;
    logic [MS_W-1:0] max_duration_ms;
  } cfg_t;

  typedef struct packed {
    logic [DUR_W-1:0] observe;
    logic [DUR_W-1:0] control;
    logic [DUR_W-1:0] standby;
  } dur_set_t;

endpackage

`default_nettype wire

### hdl/ept_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input item channel
interface ept_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] step_ms;
  logic [15:0] new_observe_ms;
  logic [15:0] new_control_ms;
  logic [15:0] new_standby_ms;

  modport source (output valid, opcode, step_ms, new_observe_ms, new_control_ms,
                  new_standby_ms, input ready);
  modport sink (input valid, opcode, step_ms, new_observe_ms, new_control_ms,
                new_standby_ms, output ready);
endinterface

// Result channel
interface ept_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phase;
  logic [16:0] timer_ms;
  logic        status;

  modport source (output valid, phase, timer_ms, status, input ready);
  modport sink (input valid, phase, timer_ms, status, output ready);
endinterface

`default_nettype wire

### hdl/ept_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ept_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ept_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output ept_pkg::cfg_t                   cfg
);
  import ept_pkg::*;

  logic                         wr_en;
  logic [ADDR_W-3:0]            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable          <= 1'b0;
      cfg.max_step_ms     <= MAX_STEP_RST;
      cfg.min_duration_ms <= MIN_DUR_RST;
      cfg.max_duration_ms <= MAX_DUR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ENABLE[ADDR_W-3:0]:   cfg.enable          <= pwdata[0];
        REG_MAX_STEP[ADDR_W-3:0]: cfg.max_step_ms     <= pwdata[MS_W-1:0];
        REG_MIN_DUR[ADDR_W-3:0]:  cfg.min_duration_ms <= pwdata[MS_W-1:0];
        REG_MAX_DUR[ADDR_W-3:0]:  cfg.max_duration_ms <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_ENABLE[ADDR_W-3:0]:   prdata = {31'd0, cfg.enable};
      REG_MAX_STEP[ADDR_W-3:0]: prdata = {16'd0, cfg.max_step_ms};
      REG_MIN_DUR[ADDR_W-3:0]:  prdata = {16'd0, cfg.min_duration_ms};
      REG_MAX_DUR[ADDR_W-3:0]:  prdata = {16'd0, cfg.max_duration_ms};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/ept_core.sv
`timescale 1ns / 1ps
`default_nettype none

module ept_core (
  input  wire logic     clk,
  input  wire logic     rst,
  input  ept_pkg::cfg_t cfg,
  ept_in_if.sink        item_in,
  ept_out_if.source     result_out
);
  import ept_pkg::*;

  // State
  logic [1:0]         phase_reg;
  logic [TIMER_W-1:0] phase_timer;
  dur_set_t           active_dur;
  dur_set_t           pending_dur;
  logic               pending_flag;

  logic [1:0]         phase_reg_next;
  logic [TIMER_W-1:0] phase_timer_next;
  dur_set_t           active_dur_next;
  dur_set_t           pending_dur_next;
  logic               pending_flag_next;
  logic               status_next;

  logic               accept;
  logic [TIMER_W:0]   sum;
  logic [TIMER_W-1:0] timer_step;
  logic [DUR_W-1:0]   cur_dur;
  logic               ok_obs;
  logic               ok_ctl;
  logic               ok_stb;

  function automatic logic dur_ok(input logic [MS_W-1:0] v, input cfg_t c);
    logic in_range;
    in_range = (v >= c.min_duration_ms) && (v <= c.max_duration_ms);
    return in_range && (v[MS_W-1:DUR_W] == '0);
  endfunction

  // Output register frees the input side whenever it is empty or being drained
  assign item_in.ready = !result_out.valid || result_out.ready;
  assign accept        = item_in.valid && item_in.ready;

  assign ok_obs = dur_ok(item_in.new_observe_ms, cfg);
  assign ok_ctl = dur_ok(item_in.new_control_ms, cfg);
  assign ok_stb = dur_ok(item_in.new_standby_ms, cfg);

  // Timer advance with step limit and saturation
  always_comb begin
    sum = {1'b0, phase_timer} + {{(TIMER_W+1-MS_W){1'b0}}, item_in.step_ms[MS_W-1:0]};
    if (item_in.step_ms > {{(STEP_W-MS_W){1'b0}}, cfg.max_step_ms}) begin
      timer_step = '0;
    end else if (sum[TIMER_W]) begin
      timer_step = TIMER_MAX;
    end else begin
      timer_step = sum[TIMER_W-1:0];
    end
  end

  // Next state for one item
  always_comb begin
    phase_reg_next    = phase_reg;
    phase_timer_next  = phase_timer;
    active_dur_next   = active_dur;
    pending_dur_next  = pending_dur;
    pending_flag_next = pending_flag;
    status_next       = ST_OK;
    cur_dur           = active_dur.control;

    if (item_in.opcode == OP_TICK) begin
      phase_timer_next = timer_step;
      if (!cfg.enable) begin
        phase_reg_next = PH_CONTROL;
        if (timer_step >= {{(TIMER_W-DUR_W){1'b0}}, active_dur.control}) begin
          phase_timer_next = '0;
        end
      end else begin
        // Buffered durations load on a standby tick, before the compare
        if (phase_reg == PH_STANDBY && pending_flag) begin
          active_dur_next   = pending_dur;
          pending_flag_next = 1'b0;
        end
        case (phase_reg)
          PH_OBSERVE: cur_dur = active_dur_next.observe;
          PH_CONTROL: cur_dur = active_dur_next.control;
          default:    cur_dur = active_dur_next.standby;
        endcase
        if (phase_reg != 2'd3 &&
            timer_step >= {{(TIMER_W-DUR_W){1'b0}}, cur_dur}) begin
          phase_timer_next = '0;
          phase_reg_next   = (phase_reg == PH_STANDBY) ? PH_OBSERVE : phase_reg + 2'd1;
        end
      end
    end else begin
      if (ok_obs && ok_ctl && ok_stb) begin
        pending_dur_next.observe = item_in.new_observe_ms[DUR_W-1:0];
        pending_dur_next.control = item_in.new_control_ms[DUR_W-1:0];
        pending_dur_next.standby = item_in.new_standby_ms[DUR_W-1:0];
        pending_flag_next        = 1'b1;
      end else begin
        status_next = ST_ILLEGAL;
      end
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg           <= PH_CONTROL;
      phase_timer         <= '0;
      active_dur          <= '{observe: OBS_DUR_RST, control: CTL_DUR_RST,
                               standby: STB_DUR_RST};
      pending_dur         <= '{observe: OBS_DUR_RST, control: CTL_DUR_RST,
                               standby: STB_DUR_RST};
      pending_flag        <= 1'b0;
      result_out.valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase_reg        <= phase_reg_next;
        phase_timer      <= phase_timer_next;
        active_dur       <= active_dur_next;
        pending_dur      <= pending_dur_next;
        pending_flag     <= pending_flag_next;
        result_out.valid <= 1'b1;
      end else if (result_out.ready) begin
        result_out.valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result_out.phase    <= phase_reg_next;
      result_out.timer_ms <= phase_timer_next;
      result_out.status   <= status_next;
    end
  end

endmodule

`default_nettype wire

### hdl/exclusive_phase_timer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-phase sequencer (observe, control, standby) driven by tick transactions
// that carry elapsed milliseconds; set-duration transactions validate and buffer
// a new duration set that takes effect on the next enabled standby tick. One
// transaction is accepted every clock cycle while the output register is free or
// being drained, and its single result appears in the output register in the
// next cycle; the state update (timer add, saturate, compare, phase advance) is
// combinational. Registers are written over the APB port at byte offsets 0
// (enable), 4 (max_step_ms), 8 (min_duration_ms) and 12 (max_duration_ms) and
// should change only while the block is idle.
module exclusive_phase_timer_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  ept_in_if.sink                          item_in,
  ept_out_if.source                       result_out,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ept_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import ept_pkg::*;

  cfg_t cfg;

  ept_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ept_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_in    (item_in),
    .result_out (result_out)
  );

  // Every accepted transaction yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (item_in.valid && item_in.ready) |=> result_out.valid)
    else $error("accepted transaction produced no result");

  // Ticks never report an illegal duration
  a_tick_status: assert property (@(posedge clk) disable iff (rst)
    (item_in.valid && item_in.ready && item_in.opcode == OP_TICK)
      |=> (result_out.status == ST_OK))
    else $error("tick reported nonzero status");

  // Disabled ticks force the control phase
  a_disabled_control: assert property (@(posedge clk) disable iff (rst)
    (item_in.valid && item_in.ready && item_in.opcode == OP_TICK && !cfg.enable)
      |=> (result_out.phase == PH_CONTROL))
    else $error("disabled tick left control phase");

  // The phase code stays in range
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> (result_out.phase != 2'd3))
    else $error("invalid phase code on result");

endmodule

`default_nettype wire

### tb/tb_exclusive_phase_timer_top.sv
`timescale 1ns / 1ps

module tb_exclusive_phase_timer_top;
  import ept_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned CHOKE_CYCLES    = 300;
  localparam int unsigned RAND_PHASES     = 8;
  localparam int unsigned ITEMS_PER_PHASE = 240;
  localparam logic [15:0] DUR_CEIL        = 16'd16383;

  typedef struct packed {
    logic [1:0]         phase;
    logic [TIMER_W-1:0] timer_ms;
    logic               status;
  } result_t;

  // One row of the directed table: either a register write or a transaction
  typedef struct packed {
    logic        is_reg;
    logic [31:0] reg_idx;
    logic [31:0] reg_val;
    logic        opcode;
    logic [31:0] step_ms;
    logic [15:0] obs_ms;
    logic [15:0] ctl_ms;
    logic [15:0] stb_ms;
    logic        fixed;
    result_t     want;
  } stim_row_t;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  ept_in_if  item_if ();
  ept_out_if res_if ();

  exclusive_phase_timer_top uut (
    .clk(clk),
    .rst(rst),
    .item_in(item_if),
    .result_out(res_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Sequencer state as the testbench sees it
  cfg_t               cfg;
  logic [1:0]         cur_phase;
  logic [TIMER_W-1:0] phase_tmr;
  logic [DUR_W-1:0]   act_dur [3];
  logic [DUR_W-1:0]   pend_dur [3];
  logic               pend_valid;

  result_t     expected_results [$];
  stim_row_t   directed [$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  bit          no_idle    = 1'b0;
  bit          choke_req  = 1'b0;
  logic        drv_fixed  = 1'b0;
  result_t     drv_want   = '0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit duration_legal(input logic [15:0] v);
    return v >= cfg.min_duration_ms && v <= cfg.max_duration_ms && v <= DUR_CEIL;
  endfunction

  // Applies one transaction to the state copy and returns the result it yields
  function automatic result_t advance_sequencer(input logic op, input logic [31:0] step,
                                                input logic [15:0] obs,
                                                input logic [15:0] ctl,
                                                input logic [15:0] stb);
    logic [33:0] sum;
    result_t     r;
    r.status = ST_OK;
    if (op == OP_TICK) begin
      // step beyond the limit clears the timer, else accumulate with saturation
      if (step > {16'd0, cfg.max_step_ms}) begin
        phase_tmr = '0;
      end else begin
        sum = phase_tmr + step;
        phase_tmr = (sum > TIMER_MAX) ? TIMER_MAX : sum[TIMER_W-1:0];
      end
      if (!cfg.enable) begin
        cur_phase = PH_CONTROL;
        if (phase_tmr >= act_dur[PH_CONTROL]) phase_tmr = '0;
      end else begin
        // buffered durations take effect on a standby tick, before the compare
        if (cur_phase == PH_STANDBY && pend_valid) begin
          act_dur = pend_dur;
          pend_valid = 1'b0;
        end
        if (cur_phase <= PH_STANDBY && phase_tmr >= act_dur[cur_phase]) begin
          phase_tmr = '0;
          cur_phase = (cur_phase == PH_STANDBY) ? PH_OBSERVE : cur_phase + 2'd1;
        end
      end
    end else if (duration_legal(obs) && duration_legal(ctl) && duration_legal(stb)) begin
      pend_dur[0] = obs[DUR_W-1:0];
      pend_dur[1] = ctl[DUR_W-1:0];
      pend_dur[2] = stb[DUR_W-1:0];
      pend_valid = 1'b1;
    end else begin
      r.status = ST_ILLEGAL;
    end
    r.phase = cur_phase;
    r.timer_ms = phase_tmr;
    return r;
  endfunction

  // Table builders
  function automatic void dir_item(input logic op, input logic [31:0] step,
                                   input logic [15:0] obs, input logic [15:0] ctl,
                                   input logic [15:0] stb, input logic fixed,
                                   input logic [1:0] ph, input logic [TIMER_W-1:0] tm,
                                   input logic st);
    stim_row_t row;
    row = '0;
    row.opcode = op;
    row.step_ms = step;
    row.obs_ms = obs;
    row.ctl_ms = ctl;
    row.stb_ms = stb;
    row.fixed = fixed;
    row.want.phase = ph;
    row.want.timer_ms = tm;
    row.want.status = st;
    directed.push_back(row);
  endfunction

  function automatic void dir_reg(input int unsigned idx, input logic [31:0] val);
    stim_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    directed.push_back(row);
  endfunction

  // Offer one transaction; returns at the falling edge after acceptance, valid still high
  task automatic send_item(input logic op, input logic [31:0] step, input logic [15:0] obs,
                           input logic [15:0] ctl, input logic [15:0] stb,
                           input logic fixed, input result_t want);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      item_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_if.valid = 1'b1;
    item_if.opcode = op;
    item_if.step_ms = step;
    item_if.new_observe_ms = obs;
    item_if.new_control_ms = ctl;
    item_if.new_standby_ms = stb;
    drv_fixed = fixed;
    drv_want = want;
    do @(posedge clk); while (!item_if.ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every result has been taken
  task automatic settle();
    item_if.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // APB write: setup then access; the state copy follows once it lands
  task automatic write_reg(input int unsigned idx, input logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'(4 * idx);
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_ENABLE:   cfg.enable = val[0];
      REG_MAX_STEP: cfg.max_step_ms = val[15:0];
      REG_MIN_DUR:  cfg.min_duration_ms = val[15:0];
      REG_MAX_DUR:  cfg.max_duration_ms = val[15:0];
      default: ;
    endcase
  endtask

  // Predict on each accepted input transaction, check each accepted result
  always @(posedge clk) begin : monitor
    result_t pred;
    result_t got;
    result_t want;
    if (!rst && item_if.valid && item_if.ready) begin
      pred = advance_sequencer(item_if.opcode, item_if.step_ms, item_if.new_observe_ms,
                               item_if.new_control_ms, item_if.new_standby_ms);
      expected_results.push_back(drv_fixed ? drv_want : pred);
    end
    if (!rst && res_if.valid && res_if.ready) begin
      got.phase = res_if.phase;
      got.timer_ms = res_if.timer_ms;
      got.status = res_if.status;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: phase %0d timer %0d status %0d",
                 $time, got.phase, got.timer_ms, got.status);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.phase !== want.phase) begin
          $display("%0t: phase expected %0d, actual %0d", $time, want.phase, got.phase);
          mismatches++;
        end
        if (got.timer_ms !== want.timer_ms) begin
          $display("%0t: timer_ms expected %0d, actual %0d",
                   $time, want.timer_ms, got.timer_ms);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
          mismatches++;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned stall;
    res_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (choke_req) begin
        choke_req = 1'b0;
        res_if.ready = 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready = 1'b1;
      do @(posedge clk); while (!res_if.valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    logic [31:0] step;
    logic [15:0] dur [3];
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] near;
    logic [15:0] lim;
    logic [31:0] r_en;
    logic [31:0] r_step;
    logic [31:0] r_min;
    logic [31:0] r_max;
    int unsigned p;
    int unsigned k;
    int unsigned pick;
    int unsigned sel;

    item_if.valid = 1'b0;
    item_if.opcode = OP_TICK;
    item_if.step_ms = '0;
    item_if.new_observe_ms = '0;
    item_if.new_control_ms = '0;
    item_if.new_standby_ms = '0;

    // state copy at reset
    cfg.enable = 1'b0;
    cfg.max_step_ms = MAX_STEP_RST;
    cfg.min_duration_ms = MIN_DUR_RST;
    cfg.max_duration_ms = MAX_DUR_RST;
    cur_phase = PH_CONTROL;
    phase_tmr = '0;
    act_dur[0] = OBS_DUR_RST;
    act_dur[1] = CTL_DUR_RST;
    act_dur[2] = STB_DUR_RST;
    pend_dur = act_dur;
    pend_valid = 1'b0;

    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Directed table. Disabled after reset: control phase on an 800 ms cycle.
    dir_item(OP_TICK, 0, 0, 0, 0, 1, PH_CONTROL, 0, ST_OK);
    dir_item(OP_TICK, 1000, 0, 0, 0, 1, PH_CONTROL, 0, ST_OK);       // step at limit, wraps
    dir_item(OP_TICK, 1001, 0, 0, 0, 1, PH_CONTROL, 0, ST_OK);       // over limit clears
    dir_item(OP_TICK, 32'hFFFF_FFFF, 0, 0, 0, 1, PH_CONTROL, 0, ST_OK);
    dir_item(OP_TICK, 799, 0, 0, 0, 1, PH_CONTROL, 799, ST_OK);
    dir_item(OP_TICK, 1, 0, 0, 0, 1, PH_CONTROL, 0, ST_OK);
    // duration check: below min, above max, all-ones, zeros
    dir_item(OP_SET_DUR, 0, 9, 100, 100, 1, PH_CONTROL, 0, ST_ILLEGAL);
    dir_item(OP_SET_DUR, 0, 100, 10001, 100, 1, PH_CONTROL, 0, ST_ILLEGAL);
    dir_item(OP_SET_DUR, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, PH_CONTROL, 0, ST_ILLEGAL);
    dir_item(OP_SET_DUR, 0, 0, 0, 0, 1, PH_CONTROL, 0, ST_ILLEGAL);
    // accepted sets, the second overwrites the first; disabled, so none loads
    dir_item(OP_SET_DUR, 0, 10, 10000, 10, 1, PH_CONTROL, 0, ST_OK);
    dir_item(OP_SET_DUR, 0, 20, 30, 40, 1, PH_CONTROL, 0, ST_OK);
    dir_item(OP_TICK, 500, 0, 0, 0, 1, PH_CONTROL, 500, ST_OK);
    // enabled: control ends, standby loads the buffered set
    dir_reg(REG_ENABLE, 1);
    dir_item(OP_TICK, 300, 0, 0, 0, 1, PH_STANDBY, 0, ST_OK);
    dir_item(OP_TICK, 0, 0, 0, 0, 0, PH_OBSERVE, 0, ST_OK);
    dir_item(OP_TICK, 40, 0, 0, 0, 0, PH_OBSERVE, 0, ST_OK);
    dir_item(OP_TICK, 20, 0, 0, 0, 0, PH_OBSERVE, 0, ST_OK);
    // stored width caps durations; zero durations once min is zero
    dir_reg(REG_MIN_DUR, 0);
    dir_reg(REG_MAX_DUR, 16'hFFFF);
    dir_item(OP_SET_DUR, 0, 16384, 100, 100, 0, PH_OBSERVE, 0, ST_OK);
    dir_item(OP_SET_DUR, 0, 16383, 1, 1, 0, PH_OBSERVE, 0, ST_OK);
    dir_item(OP_SET_DUR, 0, 0, 0, 0, 0, PH_OBSERVE, 0, ST_OK);
    dir_item(OP_TICK, 30, 0, 0, 0, 0, PH_OBSERVE, 0, ST_OK);
    dir_item(OP_TICK, 0, 0, 0, 0, 0, PH_OBSERVE, 0, ST_OK);
    dir_item(OP_TICK, 0, 0, 0, 0, 0, PH_OBSERVE, 0, ST_OK);
    dir_item(OP_TICK, 0, 0, 0, 0, 0, PH_OBSERVE, 0, ST_OK);
    // step limit extremes
    dir_reg(REG_MAX_STEP, 0);
    dir_item(OP_TICK, 1, 0, 0, 0, 0, PH_OBSERVE, 0, ST_OK);
    dir_reg(REG_MAX_STEP, 16'hFFFF);
    dir_item(OP_TICK, 65535, 0, 0, 0, 0, PH_OBSERVE, 0, ST_OK);
    dir_item(OP_TICK, 65536, 0, 0, 0, 0, PH_OBSERVE, 0, ST_OK);
    // min above max rejects everything
    dir_reg(REG_MIN_DUR, 100);
    dir_reg(REG_MAX_DUR, 50);
    dir_item(OP_SET_DUR, 0, 75, 75, 75, 1, PH_STANDBY, 0, ST_ILLEGAL);
    dir_reg(REG_ENABLE, 0);
    dir_item(OP_TICK, 5, 0, 0, 0, 0, PH_OBSERVE, 0, ST_OK);

    foreach (directed[i]) begin
      row = directed[i];
      if (row.is_reg) begin
        settle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.opcode, row.step_ms, row.obs_ms, row.ctl_ms, row.stb_ms,
                  row.fixed, row.want);
      end
    end

    // Random phases, each under its own register setting
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin r_en = 1; r_step = 1000;  r_min = 10;    r_max = 10000; end
        1: begin r_en = 1; r_step = 65535; r_min = 0;     r_max = 65535; end
        2: begin r_en = 1; r_step = 0;     r_min = 0;     r_max = 0;     end
        3: begin r_en = 0; r_step = 500;   r_min = 10;    r_max = 1000;  end
        4: begin r_en = 1; r_step = 300;   r_min = 1;     r_max = 400;   end
        5: begin r_en = 1; r_step = 65535; r_min = 65535; r_max = 65535; end
        6: begin r_en = 1; r_step = 2000;  r_min = 300;   r_max = 200;   end
        default: begin
          r_en = 1;
          r_step = $urandom_range(0, 65535);
          r_min = $urandom_range(0, 500);
          r_max = r_min + $urandom_range(0, 2000);
        end
      endcase
      settle();
      write_reg(REG_ENABLE, r_en);
      write_reg(REG_MAX_STEP, r_step);
      write_reg(REG_MIN_DUR, r_min);
      write_reg(REG_MAX_DUR, r_max);
      // long result hold-off while transactions keep coming
      if (p == 1) choke_req = 1'b1;

      lo = cfg.min_duration_ms;
      hi = (cfg.max_duration_ms < DUR_CEIL) ? cfg.max_duration_ms : DUR_CEIL;
      near = (lo <= hi && hi - lo > 300) ? lo + 16'd300 : hi;
      lim = (cfg.max_step_ms < 16'd400) ? cfg.max_step_ms : 16'd400;

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          // tick: mostly in-range steps that walk the phases
          sel = $urandom_range(0, 9);
          if (sel < 7) step = $urandom_range(0, lim);
          else if (sel == 7) step = {16'd0, cfg.max_step_ms};
          else if (sel == 8) step = {16'd0, cfg.max_step_ms} + 32'd1 + $urandom_range(0, 100);
          else step = $urandom();
          send_item(OP_TICK, step, 0, 0, 0, 1'b0, '0);
        end else begin
          // set durations: legal, legal with one field corrupted, or noise
          for (int d = 0; d < 3; d++) begin
            if (lo > hi) dur[d] = $urandom_range(0, 65535);
            else if ($urandom_range(0, 9) == 0) dur[d] = $urandom_range(lo, hi);
            else dur[d] = $urandom_range(lo, near);
          end
          if (pick >= 92) dur[$urandom_range(0, 2)] = $urandom_range(0, 65535);
          send_item(OP_SET_DUR, $urandom(), dur[0], dur[1], dur[2], 1'b0, '0);
        end
      end
    end

    // Drain and finish
    no_idle = 1'b0;
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ept_pkg.sv
hdl/ept_if.sv
hdl/ept_regs.sv
hdl/ept_core.sv
hdl/exclusive_phase_timer_top.sv
tb/tb_exclusive_phase_timer_top.sv
